### rtl/cstt_pkg.sv
// Shared types and constants for the clamped step toward target block.
// No dependencies.
package cstt_pkg;

  localparam int TABLE_LEN = 31;
  localparam int VW = 36;   // CORDIC x/y datapath width
  localparam int AW = 35;   // Q30 angle width

  localparam logic signed [AW-1:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 35'sd1686629713;
  localparam logic signed [AW-1:0] ANG_TWO_PI  = 35'sd6746518852;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_SPEED_GAIN = 2'd0,
    REG_MAX_STEP   = 2'd1,
    REG_ANGLE_THR  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_VEC,
    B_MAG,
    B_ROT,
    B_DONE
  } bstate_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [30:0]        step;
    logic signed [31:0] set_x;
    logic signed [31:0] set_y;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - idx);
    endcase
    return r;
  endfunction

endpackage

### rtl/cstt_queue.sv
// Two-entry queue between the front and back parts.
// Depends on cstt_pkg.
module cstt_queue
  import cstt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output qstat_t stat
);

  entry_t     mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign head       = mem[rptr];
  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/cstt_front.sv
// Front part: accepts items, forms the clamped step length.
// Depends on cstt_pkg.
module cstt_front
  import cstt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  op_t                op,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  input  logic [31:0]        distance,
  input  logic signed [31:0] set_x,
  input  logic signed [31:0] set_y,
  input  logic [23:0]        speed_gain,
  input  logic [30:0]        max_step,
  input  logic               q_full,
  output logic               push,
  output entry_t             push_data
);

  logic               hold_valid;
  op_t                h_op;
  logic signed [31:0] h_dx, h_dy, h_sx, h_sy;
  logic [55:0]        prod;
  logic [39:0]        raw_step;

  assign in_ready = !rst && (!hold_valid || !q_full);
  assign push     = hold_valid && !q_full;
  assign raw_step = prod[55:16];

  always_comb begin
    push_data.op    = h_op;
    push_data.dx    = h_dx;
    push_data.dy    = h_dy;
    push_data.set_x = h_sx;
    push_data.set_y = h_sy;
    push_data.step  = (raw_step > {9'd0, max_step}) ? max_step : raw_step[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      h_op <= op;
      h_dx <= dx;
      h_dy <= dy;
      h_sx <= set_x;
      h_sy <= set_y;
      prod <= {32'd0, speed_gain} * {24'd0, distance};
    end
  end

endmodule

### rtl/cstt_back.sv
// Back part: CORDIC vectoring and rotation sequencer, pose update, result register.
// Depends on cstt_pkg.
module cstt_back
  import cstt_pkg::*;
#(
  parameter int ITERS     = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  entry_t             head,
  input  logic               q_empty,
  output logic               pop,
  input  logic [17:0]        angle_threshold,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [18:0] heading,
  output logic               heading_changed
);

  localparam int SH = 30 - FRAC_BITS;
  localparam logic [4:0] LAST = 5'(ITERS - 1);

  bstate_t state, state_next;
  logic [4:0]            it;
  logic signed [VW-1:0]  vx, vy;
  logic signed [AW-1:0]  vz, rz;
  logic [30:0]           step;
  logic signed [31:0]    px, py;
  logic signed [18:0]    hd;

  logic signed [VW-1:0]  shx, shy;
  logic signed [AW-1:0]  at;
  logic signed [AW-1:0]  wz;
  logic [60:0]           mprod;
  logic signed [VW-1:0]  mag;
  logic signed [VW:0]    sx_sum, sy_sum;
  logic signed [AW-1:0]  hq, habs;
  logic                  out_free;

  assign shx      = vx >>> it;
  assign shy      = vy >>> it;
  assign at       = AW'(atan_q30(it));
  assign wz       = (vz > ANG_PI) ? vz - ANG_TWO_PI :
                    (vz < -ANG_PI) ? vz + ANG_TWO_PI : vz;
  assign mprod    = {30'd0, step} * {31'd0, INV_GAIN_Q30};
  assign mag      = VW'(mprod[60:30]);
  assign sx_sum   = (VW+1)'(px) + (VW+1)'(vx);
  assign sy_sum   = (VW+1)'(py) + (VW+1)'(vy);
  assign hq       = (vz + (AW'(1) <<< (SH - 1))) >>> SH;
  assign habs     = hq[AW-1] ? -hq : hq;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: if (!q_empty && !out_valid) begin
        pop = 1'b1;
        if (head.op == OP_MOVE) begin
          if (head.dy == 0 || head.dx == 0) state_next = B_MAG;
          else                              state_next = B_VEC;
        end
      end
      B_VEC:  if (it == LAST) state_next = B_MAG;
      B_MAG:  state_next = B_ROT;
      B_ROT:  if (it == LAST) state_next = B_DONE;
      B_DONE: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  function automatic logic signed [31:0] sat32(input logic signed [VW:0] v);
    if (v > (VW+1)'(32'sh7FFFFFFF))       return 32'sh7FFFFFFF;
    else if (v < -(VW+1)'(33'sh080000000)) return 32'sh80000000;
    else                                  return v[31:0];
  endfunction

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        it   <= '0;
        step <= head.step;
        if (head.dy == 0) begin
          vz <= head.dx[31] ? ANG_PI : '0;
        end else if (head.dx == 0) begin
          vz <= head.dy[31] ? -ANG_HALF_PI : ANG_HALF_PI;
        end else if (head.dx[31]) begin
          if (!head.dy[31]) begin
            vx <= VW'(head.dy);  vy <= -VW'(head.dx); vz <= ANG_HALF_PI;
          end else begin
            vx <= -VW'(head.dy); vy <= VW'(head.dx);  vz <= -ANG_HALF_PI;
          end
        end else begin
          vx <= VW'(head.dx); vy <= VW'(head.dy); vz <= '0;
        end
      end
      B_VEC: begin
        it <= it + 5'd1;
        if (!vy[VW-1]) begin
          vx <= vx + shy; vy <= vy - shx; vz <= vz + at;
        end else begin
          vx <= vx - shy; vy <= vy + shx; vz <= vz - at;
        end
      end
      B_MAG: begin
        it <= '0;
        // wrap to [-pi, pi], then pre-rotate beyond +-pi/2
        vz <= wz;
        if (wz > ANG_HALF_PI) begin
          rz <= wz - ANG_HALF_PI; vx <= '0; vy <= mag;
        end else if (wz < -ANG_HALF_PI) begin
          rz <= wz + ANG_HALF_PI; vx <= '0; vy <= -mag;
        end else begin
          rz <= wz; vx <= mag; vy <= '0;
        end
      end
      B_ROT: begin
        it <= it + 5'd1;
        if (!rz[AW-1]) begin
          vx <= vx - shy; vy <= vy + shx; rz <= rz - at;
        end else begin
          vx <= vx + shy; vy <= vy - shx; rz <= rz + at;
        end
      end
      default: ;
    endcase
  end

  // pose and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      px        <= '0;
      py        <= '0;
      hd        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == B_IDLE && pop && head.op == OP_SET) begin
        px              <= head.set_x;
        py              <= head.set_y;
        pos_x           <= head.set_x;
        pos_y           <= head.set_y;
        heading         <= hd;
        heading_changed <= 1'b0;
        out_valid       <= 1'b1;
      end else if (state == B_DONE && out_free) begin
        px              <= sat32(sx_sum);
        py              <= sat32(sy_sum);
        pos_x           <= sat32(sx_sum);
        pos_y           <= sat32(sy_sum);
        out_valid       <= 1'b1;
        if (habs > AW'(angle_threshold)) begin
          hd              <= hq[18:0];
          heading         <= hq[18:0];
          heading_changed <= 1'b1;
        end else begin
          heading         <= hd;
          heading_changed <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/clamped_step_toward_target_top.sv
// Top level of the clamped step toward target block.
// Depends on cstt_pkg, cstt_front, cstt_queue, cstt_back.
//
// Keeps a Q16.16 position and a Q3.16 heading. Requests arrive on the
// s_ stream: s_tuser is the op (0 move, 1 set position), s_tdata the
// payload. One result per request leaves on the m_ stream.
// Config: cfg_we/cfg_index/cfg_data write speed_gain (0), max_step (1),
// angle_threshold (2); write only while the block is idle.
// A set request passes the front hold register and the queue, and the back
// loads it into the result register. For a move request the front forms
// gain*distance in one multiply, then the back runs the vectoring CORDIC,
// one multiply by the inverse gain, the rotation CORDIC (one iteration per
// cycle each, on one shared shifter pair) and the saturating update.
// Axis-aligned directions skip the vectoring pass.
// Throughput: one request at a time in the back; a two-entry queue lets
// the front take new requests meanwhile.
// Reset clears position, heading, queue and valid flags; registers
// return to their default values; s_tready stays low during reset.
// When m_tready is low the result holds and the back waits before
// starting the next request.
module clamped_step_toward_target_top
  import cstt_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int FRAC_BITS         = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // dx, dy, distance, set_x, set_y
  input  logic         s_tuser,  // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [87:0]  m_tdata,  // pos_x, pos_y, heading[18:0], heading_changed, zero pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int ITERS = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;

  logic [23:0] speed_gain;
  logic [30:0] max_step;
  logic [17:0] angle_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain      <= 24'd6554;
      max_step        <= 31'd3277;
      angle_threshold <= 18'd1144;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_GAIN: speed_gain      <= cfg_data[23:0];
        REG_MAX_STEP:   max_step        <= cfg_data;
        REG_ANGLE_THR:  angle_threshold <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  logic               q_push, q_pop;
  entry_t             q_in, q_head;
  qstat_t             q_stat;
  logic signed [31:0] pos_x, pos_y;
  logic signed [18:0] heading;
  logic               heading_changed;

  cstt_front u_front (
    .clk, .rst,
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (op_t'(s_tuser)),
    .dx        (s_tdata[31:0]),
    .dy        (s_tdata[63:32]),
    .distance  (s_tdata[95:64]),
    .set_x     (s_tdata[127:96]),
    .set_y     (s_tdata[159:128]),
    .speed_gain,
    .max_step,
    .q_full    (q_stat.full),
    .push      (q_push),
    .push_data (q_in)
  );

  cstt_queue u_queue (
    .clk, .rst,
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  cstt_back #(.ITERS(ITERS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst,
    .head      (q_head),
    .q_empty   (q_stat.empty),
    .pop       (q_pop),
    .angle_threshold,
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pos_x, .pos_y, .heading, .heading_changed
  );

  assign m_tdata = {4'd0, heading_changed, heading, pos_y, pos_x};

  // a changed heading is always nonzero (it beat a non-negative threshold)
  a_changed_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && heading_changed |-> heading != 19'd0)
    else $error("heading_changed with zero heading");

  a_no_overpush: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underpop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty && !m_tvalid)
    else $error("back popped without room");

  a_set_keeps_flag: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_head.op == OP_SET |=> m_tvalid && !heading_changed)
    else $error("set request result wrong");

endmodule

### verif/tb_clamped_step_toward_target_top.sv
// Testbench for clamped_step_toward_target_top: directed and random requests
// checked against an in-bench pose predictor. Depends on cstt_pkg and the RTL.
module tb_clamped_step_toward_target_top
  import cstt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITER = 16;
  localparam int FB = 16;

  // packed from the lowest m_tdata bit up: x, y, hdg, chg
  typedef struct packed {
    logic               chg;
    logic [18:0]        hdg;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [159:0] s_tdata = '0;  // dx, dy, distance, set_x, set_y
  logic s_tuser = 1'b0;        // op
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [87:0] m_tdata;        // pos_x, pos_y, heading, heading_changed
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  always #5 clk = ~clk;

  clamped_step_toward_target_top i_dut (.*);

  // Predictor state, mirrors the block's registers.
  logic [23:0] gain_q;
  logic [30:0] max_step_q;
  logic [17:0] thresh_q;
  longint pos_x_q, pos_y_q, heading_q;
  pose_t pose_queue[$];
  int errors = 0;
  bit stall_long = 1'b0;
  bit sender_bursty = 1'b1;

  longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768};
  localparam longint PI_Q30 = 64'd3373259426;
  localparam longint HPI_Q30 = 64'd1686629713;

  // >>> on longint is arithmetic, i.e. floor for negatives.
  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint heading_of(longint dx, longint dy);
    longint x, y, z, nx, ny;
    if (dy == 0) return (dx < 0) ? PI_Q30 : 0;
    if (dx == 0) return (dy < 0) ? -HPI_Q30 : HPI_Q30;
    if (dx < 0) begin
      if (dy > 0) begin
        x = dy; y = -dx; z = HPI_Q30;
      end else begin
        x = -dy; y = dx; z = -HPI_Q30;
      end
    end else begin
      x = dx; y = dy; z = 0;
    end
    for (int i = 0; i < ITER; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
      end
      x = nx; y = ny;
    end
    if (z > PI_Q30) z -= 2 * PI_Q30;
    if (z < -PI_Q30) z += 2 * PI_Q30;
    return z;
  endfunction

  task automatic predict_pose(op_t op, longint dx, longint dy, longint dlen,
                              longint sx, longint sy);
    longint step, ang, mag, x, y, nx, ny, hq, habs;
    pose_t p;
    p.chg = 1'b0;
    if (op == OP_SET) begin
      pos_x_q = sx; pos_y_q = sy;
    end else begin
      step = (longint'(gain_q) * dlen) >> 16;
      if (step > longint'(max_step_q)) step = max_step_q;
      ang = heading_of(dx, dy);
      mag = (step * 64'd652032874) >> 30;
      hq = (ang + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
      x = mag; y = 0;
      if (ang > HPI_Q30) begin
        x = 0; y = mag; ang -= HPI_Q30;
      end else if (ang < -HPI_Q30) begin
        x = 0; y = -mag; ang += HPI_Q30;
      end
      for (int i = 0; i < ITER; i++) begin
        if (ang >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); ang -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); ang += atan_tab[i];
        end
        x = nx; y = ny;
      end
      pos_x_q = sat32(pos_x_q + x);
      pos_y_q = sat32(pos_y_q + y);
      habs = (hq < 0) ? -hq : hq;
      if (habs > longint'(thresh_q)) begin
        heading_q = hq; p.chg = 1'b1;
      end
    end
    p.x = pos_x_q[31:0]; p.y = pos_y_q[31:0]; p.hdg = heading_q[18:0];
    pose_queue.push_back(p);
  endtask

  // Sends one request; predicts at acceptance. Random gaps before bursts.
  // tvalid stays high into the next request; drain drops it.
  task automatic send_request(op_t op, logic [31:0] dx, logic [31:0] dy,
                              logic [31:0] dlen, logic [31:0] sx, logic [31:0] sy);
    if (sender_bursty && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {sy, sx, dlen, dy, dx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pose(op, longint'(signed'(dx)), longint'(signed'(dy)), longint'(dlen),
                 longint'(signed'(sx)), longint'(signed'(sy)));
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [30:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_SPEED_GAIN: gain_q = val[23:0];
      REG_MAX_STEP: max_step_q = val;
      default: thresh_q = val[17:0];
    endcase
  endtask

  // Every result arrives; then let the back settle before a register write.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pose_queue.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Receiver: own stall pattern, plus one long hold-off on request.
  always @(negedge clk) begin
    if (stall_long) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    pose_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[83:0];
      if (pose_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pose_queue.pop_front();
        if (got.x !== want.x)
          $display("%0t: pos_x exp %h got %h", $time, want.x, got.x);
        if (got.y !== want.y)
          $display("%0t: pos_y exp %h got %h", $time, want.y, got.y);
        if (got.hdg !== want.hdg)
          $display("%0t: heading exp %h got %h", $time, want.hdg, got.hdg);
        if (got.chg !== want.chg)
          $display("%0t: heading_changed exp %b got %b", $time, want.chg, got.chg);
        if (got !== want) errors++;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 200) - 100;
      1: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 15);
      2: return -($urandom_range(1, 1 << 20));
      3: return 32'(0);
      default: return $urandom;
    endcase
  endfunction

  // Axes, zero vector, extremes of every field, both ops, saturation.
  task automatic test_directed;
    send_request(OP_MOVE, 0, 0, 32'h0001_0000, 0, 0);
    send_request(OP_MOVE, -5, 0, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_MOVE, 7, 0, 32'h0001_0000, 0, 0);
    send_request(OP_MOVE, 0, 9, 32'h0001_0000, 0, 0);
    send_request(OP_MOVE, 0, -9, 32'h0001_0000, 0, 0);
    send_request(OP_MOVE, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_MOVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    send_request(OP_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h10000, 0, 0);
    send_request(OP_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h10000, 0, 0);
    send_request(OP_MOVE, 1, 1, 32'h10000, 0, 0);
    send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h7FFF_FFF0, 32'h8000_0010);
    drain();
    write_reg(REG_MAX_STEP, 31'h7FFF_FFFF);
    write_reg(REG_SPEED_GAIN, 31'h0FF_FFFF);
    send_request(OP_MOVE, 1, 0, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_MOVE, 0, -1, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_MOVE, -1, 1, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_SET, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_MOVE, -1, -1, 32'hFFFF_FFFF, 0, 0);
    drain();
  endtask

  task automatic test_random(int n);
    logic [31:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = rand_coord(); b = rand_coord();
      if ($urandom_range(0, 7) == 0)
        send_request(OP_SET, $urandom, $urandom, $urandom,
                     ($urandom_range(0, 1) ? $urandom : a), b);
      else
        send_request(OP_MOVE, a, b,
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22),
                     $urandom, $urandom);
    end
    drain();
  endtask

  // Config sweeps: extremes and random values, re-randomized per phase.
  task automatic test_config_sweep;
    write_reg(REG_SPEED_GAIN, '0); write_reg(REG_MAX_STEP, '0);
    write_reg(REG_ANGLE_THR, '0);
    test_random(60);
    write_reg(REG_SPEED_GAIN, 31'h0FF_FFFF); write_reg(REG_MAX_STEP, 31'h7FFF_FFFF);
    write_reg(REG_ANGLE_THR, 31'd205887);
    test_random(100);
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_SPEED_GAIN, 31'($urandom_range(0, 24'hFF_FFFF)));
      write_reg(REG_MAX_STEP, 31'($urandom_range(0, 31'h7FFF_FFFF)));
      write_reg(REG_ANGLE_THR, 31'($urandom_range(0, 205887)));
      test_random(155);
    end
  endtask

  // Receiver held off while requests keep coming, sent with no gaps throughout.
  task automatic test_backpressure;
    fork
      begin
        stall_long = 1'b1;
        repeat (400) @(negedge clk);
        stall_long = 1'b0;
      end
      begin
        sender_bursty = 1'b0;
        test_random(40);
        sender_bursty = 1'b1;
      end
    join
  endtask

  initial begin
    gain_q = 24'd6554; max_step_q = 31'd3277; thresh_q = 18'd1144;
    pos_x_q = 0; pos_y_q = 0; heading_q = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_config_sweep();
    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #3ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
